// ===== design/ppl_pkg.sv =====
// shared types, widths and codes for the payload length calculator
package ppl_pkg;

  // field widths
  localparam int CNT_W    = 21;
  localparam int PAY_W    = 18;
  localparam int PAD_W    = 6;
  localparam int BPS_W    = 7;
  localparam int BIDX_W   = 6;
  localparam int SPW_W    = 4;
  localparam int ITEM_W   = 22;
  localparam int OPA_W    = 23;
  localparam int RCP_W    = 29;
  localparam int RCP_SHIFT = 28;
  localparam int PROD_W   = 52;
  localparam int TB_W     = 29;
  localparam int TOT_W    = 20;
  localparam int WIN_W    = 16;
  localparam int PF_W     = 27;
  localparam int USED_W   = 11;
  localparam int TDATA_W  = 48;
  localparam int TUSER_IN_W  = 2;
  localparam int TUSER_OUT_W = 2;

  // command codes
  localparam logic CMD_TO_PAYLOAD = 1'b0;
  localparam logic CMD_TO_SAMPLES = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_BPS  = 2'd0;
  localparam logic [1:0] CFG_CPLX = 2'd1;
  localparam logic [1:0] CFG_PEFF = 2'd2;

  // packing constants
  localparam logic [BPS_W-1:0] BPS_MIN     = 7'd1;
  localparam logic [BPS_W-1:0] BPS_MAX     = 7'd64;
  localparam logic [BPS_W-1:0] BPS_RESET   = 7'd16;
  localparam logic [BPS_W-1:0] WORD32_BITS = 7'd32;
  localparam logic [BPS_W-1:0] WORD64_BITS = 7'd64;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_UNF = 2'd2
  } status_t;

  typedef struct packed {
    logic [BPS_W-1:0] bps;
    logic             cplx;
    logic             peff;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic             count_scalar;
    logic [CNT_W-1:0] sample_count;
    logic [PAY_W-1:0] payload_bytes;
    logic [PAD_W-1:0] pad_bits;
  } item_t;

  // stage 1: decoded packing and multiplier operands
  typedef struct packed {
    logic             cmd;
    logic             pk;
    logic             wide;
    logic             mult2;
    logic             zero;
    logic             unf;
    logic [SPW_W-1:0] spw;
    logic [BPS_W-1:0] bps;
    logic [OPA_W-1:0] opa;
    logic [RCP_W-1:0] opb;
    logic [TOT_W-1:0] total;
  } prep_t;

  // stage 2: product
  typedef struct packed {
    prep_t             p;
    logic [PROD_W-1:0] prod;
  } mul_t;

  // stage 3: quotient decoded
  typedef struct packed {
    logic             cmd;
    logic             zero;
    logic             pk;
    logic             wide;
    logic [BPS_W-1:0] bps;
    logic [OPA_W-1:0] n;
    logic [OPA_W-1:0] qs;
    logic [PF_W-1:0]  pay_full;
    logic [4:0]       pad_pk;
    logic [CNT_W-1:0] scount;
    status_t          st;
  } mid_t;

  typedef struct packed {
    logic [CNT_W-1:0] scount;
    logic [PAY_W-1:0] pay;
    logic [PAD_W-1:0] pad;
    status_t          status;
  } result_t;

endpackage

// ===== design/packet_payload_length_calculator.sv =====
// top level of the payload length calculator: config registers and pipeline control
//
//  channel  | dir | beat holds
//  s_axis   | in  | tdata: sample count, payload bytes, pad bits; tuser: cmd, count_scalar
//  m_axis   | out | tdata: sample count, payload bytes, pad bits; tuser: status
//  cfg      | in  | cfg_index selects the register, cfg_data is its new value
//
//  one beat per cycle sustained while m_axis_tready is high
//  a result passes through the four register stages around the 23 x 29 multiplier
//  rst clears the stage valid bits and loads packing 16, real, link efficient
//  m_axis_tready low holds the result; empty stages upstream still fill
//  cfg_ready is always high
module packet_payload_length_calculator import ppl_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 262140
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [20:0] sample_count_in, [38:21] payload_bytes_in, [44:39] pad_bits_in, [47:45] zero
  input  logic [TDATA_W-1:0]     s_axis_tdata,
  // [0] cmd, [1] count_scalar
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [20:0] sample_count_out, [38:21] payload_bytes_out, [44:39] pad_bits_out, [47:45] zero
  output logic [TDATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [TUSER_OUT_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [BPS_W-1:0]       cfg_data
);

  cfg_t    cfg;
  item_t   item;
  prep_t   prep_q;
  mul_t    mul_q;
  result_t res;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bps  <= BPS_RESET;
      cfg.cplx <= 1'b0;
      cfg.peff <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BPS:  cfg.bps  <= cfg_data;
        CFG_CPLX: cfg.cplx <= cfg_data[0];
        CFG_PEFF: cfg.peff <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // unpack the input beat
  assign item.cmd           = s_axis_tuser[0];
  assign item.count_scalar  = s_axis_tuser[1];
  assign item.sample_count  = s_axis_tdata[20:0];
  assign item.payload_bytes = s_axis_tdata[38:21];
  assign item.pad_bits      = s_axis_tdata[44:39];

  // per-stage ready: a stage loads when empty or when its successor moves
  assign rdy4 = ~v4 | m_axis_tready;
  assign rdy3 = ~v3 | rdy4;
  assign rdy2 = ~v2 | rdy3;
  assign rdy1 = ~v1 | rdy2;
  assign s_axis_tready = rdy1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  ppl_prep u_prep (
    .clk  (clk),
    .en   (rdy1),
    .cfg  (cfg),
    .item (item),
    .q    (prep_q)
  );

  ppl_mul u_mul (
    .clk (clk),
    .en  (rdy2),
    .d   (prep_q),
    .q   (mul_q)
  );

  ppl_post #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_post (
    .clk    (clk),
    .en_mid (rdy3),
    .en_out (rdy4),
    .d      (mul_q),
    .res    (res)
  );

  // pack the output beat
  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {3'b000, res.pad, res.pay, res.scount};
  assign m_axis_tuser  = res.status;

endmodule

// ===== design/ppl_prep.sv =====
// input stage: packing decode, reciprocal tables and multiplier operand select
module ppl_prep import ppl_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cfg_t  cfg,
  input  item_t item,
  output prep_t q
);

  logic [RCP_W-1:0] rcp_bps [1 << BIDX_W];
  logic [RCP_W-1:0] rcp_spw [1 << BIDX_W];
  logic [SPW_W-1:0] spw_tbl [1 << BIDX_W];

  logic [BPS_W-1:0]  bps_eff;
  logic [BIDX_W-1:0] bidx;
  logic              pow2;
  logic              pk;
  logic              wide;
  logic              mult2;
  logic [ITEM_W-1:0] items;
  logic [CNT_W-1:0]  pay_bits;
  logic [CNT_W-1:0]  avail;
  logic              unf;
  logic [WIN_W-1:0]  words_in;
  logic [SPW_W-1:0]  spw;
  logic [OPA_W-1:0]  opa;
  logic [RCP_W-1:0]  opb;

  // constant tables per packing size: ceil(2^28/d), samples per word and its reciprocal
  for (genvar g = 0; g < (1 << BIDX_W); g++) begin : g_tbl
    localparam int unsigned D   = g + 1;
    localparam int unsigned SPW = ((D > 32) ? 64 : 32) / D;
    localparam int unsigned RB  = ((1 << RCP_SHIFT) + D - 1) / D;
    localparam int unsigned RS  = ((1 << RCP_SHIFT) + SPW - 1) / SPW;
    assign rcp_bps[g] = RCP_W'(RB);
    assign rcp_spw[g] = RCP_W'(RS);
    assign spw_tbl[g] = SPW_W'(SPW);
  end

  // clamp packing size to 1..64
  always_comb begin
    if (cfg.bps == '0) begin
      bps_eff = BPS_MIN;
    end else if (cfg.bps > BPS_MAX) begin
      bps_eff = BPS_MAX;
    end else begin
      bps_eff = cfg.bps;
    end
  end

  assign bidx  = BIDX_W'(bps_eff - BPS_MIN);
  assign pow2  = (bps_eff & (bps_eff - BPS_MIN)) == '0;
  assign pk    = pow2 | ~cfg.peff;
  assign wide  = ~pk & (bps_eff > WORD32_BITS);
  assign mult2 = cfg.cplx & ~item.count_scalar;
  assign spw   = spw_tbl[bidx];

  // packed item count and usable payload bits
  assign items    = mult2 ? {item.sample_count, 1'b0} : {1'b0, item.sample_count};
  assign pay_bits = {item.payload_bytes, 3'b000};
  assign unf      = CNT_W'(item.pad_bits) > pay_bits;
  assign avail    = pay_bits - CNT_W'(item.pad_bits);
  assign words_in = wide ? WIN_W'(item.payload_bytes >> 3) : WIN_W'(item.payload_bytes >> 2);

  // operand select for the shared multiplier
  always_comb begin
    if (item.cmd == CMD_TO_PAYLOAD) begin
      if (pk) begin
        opa = OPA_W'(items);
        opb = RCP_W'(bps_eff);
      end else begin
        opa = OPA_W'(items) + OPA_W'(spw) - OPA_W'(1);
        opb = rcp_spw[bidx];
      end
    end else begin
      opb = rcp_bps[bidx];
      if (pk) begin
        opa = OPA_W'(avail);
      end else begin
        opa = OPA_W'(item.pad_bits);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.cmd   <= item.cmd;
      q.pk    <= pk;
      q.wide  <= wide;
      q.mult2 <= mult2;
      q.zero  <= item.sample_count == '0;
      q.unf   <= unf;
      q.spw   <= spw;
      q.bps   <= bps_eff;
      q.opa   <= opa;
      q.opb   <= opb;
      q.total <= TOT_W'(spw) * TOT_W'(words_in);
    end
  end

endmodule

// ===== design/ppl_mul.sv =====
// multiplier stage: one 23 x 29 product per beat
module ppl_mul import ppl_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  prep_t d,
  output mul_t  q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q.p    <= d;
      q.prod <= PROD_W'(d.opa) * PROD_W'(d.opb);
    end
  end

endmodule

// ===== design/ppl_post.sv =====
// quotient decode, remainder and pad, overflow saturation and result select
module ppl_post import ppl_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 262140
) (
  input  logic    clk,
  input  logic    en_mid,
  input  logic    en_out,
  input  mul_t    d,
  output result_t res
);

  localparam int MAX4 = (MAX_PAYLOAD_BYTES / 4) * 4;
  localparam int MAX8 = (MAX_PAYLOAD_BYTES / 8) * 8;

  logic [OPA_W-1:0]  quo;
  logic [TB_W-1:0]   tbits;
  logic [TB_W:0]     tb_up;
  logic [PF_W-1:0]   pay_full;
  logic [OPA_W-1:0]  tot_ext;
  logic [CNT_W-1:0]  scount;
  status_t           st;
  mid_t              m;

  logic [SPW_W-1:0]  rem;
  logic [SPW_W-1:0]  last;
  logic [USED_W-1:0] used;
  logic [BPS_W-1:0]  wbits;
  logic [PAD_W-1:0]  pad_np;
  logic              ovf;
  result_t           res_next;

  // quotient from the reciprocal product, bit total from the plain product
  assign quo     = d.prod[RCP_SHIFT +: OPA_W];
  assign tbits   = d.prod[TB_W-1:0];
  assign tb_up   = (TB_W + 1)'(tbits) + (TB_W + 1)'(31);
  assign tot_ext = OPA_W'(d.p.total);

  // payload before saturation
  always_comb begin
    if (d.p.pk) begin
      pay_full = PF_W'({tb_up[TB_W:5], 2'b00});
    end else if (d.p.wide) begin
      pay_full = PF_W'({quo, 3'b000});
    end else begin
      pay_full = PF_W'({quo, 2'b00});
    end
  end

  // sample count for the payload to samples command
  always_comb begin
    scount = '0;
    st     = ST_OK;
    if (d.p.unf) begin
      st = ST_UNF;
    end else if (d.p.pk) begin
      scount = CNT_W'(quo >> d.p.mult2);
    end else if (quo > tot_ext) begin
      st = ST_UNF;
    end else begin
      scount = CNT_W'((tot_ext - quo) >> d.p.mult2);
    end
  end

  always_ff @(posedge clk) begin
    if (en_mid) begin
      m.cmd      <= d.p.cmd;
      m.zero     <= d.p.zero;
      m.pk       <= d.p.pk;
      m.wide     <= d.p.wide;
      m.bps      <= d.p.bps;
      m.n        <= d.p.opa;
      m.qs       <= OPA_W'(quo * OPA_W'(d.p.spw));
      m.pay_full <= pay_full;
      m.pad_pk   <= 5'(5'd0 - tbits[4:0]);
      m.scount   <= scount;
      m.st       <= st;
    end
  end

  // items in the last word and the pad they leave
  assign rem    = SPW_W'(m.n - m.qs);
  assign last   = rem + SPW_W'(1);
  assign used   = USED_W'(last) * USED_W'(m.bps);
  assign wbits  = m.wide ? WORD64_BITS : WORD32_BITS;
  assign pad_np = PAD_W'(wbits - BPS_W'(used));
  assign ovf    = m.pay_full > PF_W'(MAX_PAYLOAD_BYTES);

  // final select per command
  always_comb begin
    res_next = '{scount: '0, pay: '0, pad: '0, status: ST_OK};
    if (m.cmd == CMD_TO_SAMPLES) begin
      res_next.scount = m.scount;
      res_next.status = m.st;
    end else if (m.zero) begin
      res_next.status = ST_OK;
    end else if (ovf) begin
      res_next.pay    = m.wide ? PAY_W'(MAX8) : PAY_W'(MAX4);
      res_next.status = ST_OVF;
    end else begin
      res_next.pay = PAY_W'(m.pay_full);
      res_next.pad = m.pk ? PAD_W'(m.pad_pk) : pad_np;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res <= res_next;
    end
  end

endmodule

// ===== design/ppl_checker.sv =====
// port-level checks for the payload length calculator, bound to the top level
module ppl_checker import ppl_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_W-1:0]     m_axis_tdata,
  input logic [TUSER_OUT_W-1:0] m_axis_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // payload is always whole 32-bit words
  a_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[22:21] == 2'b00)
    else $error("payload bytes not a multiple of four");

  // pad underflow gives an all-zero beat
  a_unf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_UNF |-> m_axis_tdata[44:0] == '0)
    else $error("underflow result not zero");

  // saturated payload carries no pad and no sample count
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_OVF |->
      m_axis_tdata[20:0] == '0 && m_axis_tdata[44:39] == '0)
    else $error("overflow result has pad or samples");

endmodule

bind packet_payload_length_calculator ppl_checker u_ppl_checker (.*);

// ===== dv/packet_payload_length_calculator_tb.sv =====
// testbench for the payload length calculator: directed table, random sizing, scoreboard
module packet_payload_length_calculator_tb;
  import ppl_pkg::*;

  localparam int PAYLOAD_LIMIT = 262140;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 383;
  localparam int RECONFIG_EVERY = 48;

  // one directed case: packing to use, the beat, and an optional hand-written answer
  typedef struct packed {
    logic [BPS_W-1:0] bps;
    logic             cplx;
    logic             peff;
    item_t            beat;
    logic             typed;
    result_t          want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [20:0] sample_count_in, [38:21] payload_bytes_in, [44:39] pad_bits_in, [47:45] zero
  logic [TDATA_W-1:0]     s_axis_tdata;
  // [0] cmd, [1] count_scalar
  logic [TUSER_IN_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [20:0] sample_count_out, [38:21] payload_bytes_out, [44:39] pad_bits_out, [47:45] zero
  logic [TDATA_W-1:0]     m_axis_tdata;
  // [1:0] status
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [BPS_W-1:0]       cfg_data;

  // packing as the testbench believes the block holds it
  logic [BPS_W-1:0] cur_bps;
  logic             cur_cplx;
  logic             cur_peff;

  result_t  pending_sizes[$];
  dir_row_t dir_rows[$];
  int       mismatch_count = 0;
  int       src_idle_pct;
  int       sink_idle_pct;
  int       hold_left = 0;
  logic     hold_req;
  logic     hold_taken = 1'b0;
  logic     pin_on;
  result_t  pin_res;

  packet_payload_length_calculator #(
    .MAX_PAYLOAD_BYTES(PAYLOAD_LIMIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sizing predictor: sample count to payload and pad, or payload and pad to sample count
  function automatic result_t calc_payload_size(item_t it);
    longint unsigned b, mult, wbits, wbytes, items, tbits, words, spw, last;
    longint unsigned pay, pad, cnt, total, padsmp, avail;
    logic    dense;
    result_t r;
    b = cur_bps;
    if (b == 0) b = 1;
    if (b > 64) b = 64;
    mult = (cur_cplx && !it.count_scalar) ? 2 : 1;
    dense = ((b & (b - 1)) == 0) || !cur_peff;
    wbits = (!dense && b > 32) ? 64 : 32;
    wbytes = wbits / 8;
    cnt = 0;
    pay = 0;
    pad = 0;
    r.status = ST_OK;
    if (it.cmd == CMD_TO_PAYLOAD) begin
      items = longint'(it.sample_count) * mult;
      if (items == 0) begin
        pay = 0;
        pad = 0;
      end else if (dense) begin
        // back-to-back bits, rounded up to whole 32-bit words
        tbits = items * b;
        words = ((tbits + 7) / 8 + 3) / 4;
        pad = words * 32 - tbits;
        pay = words * 4;
      end else begin
        // whole samples per word, remainder of the last word is pad
        spw = wbits / b;
        words = (items + spw - 1) / spw;
        last = items - (words - 1) * spw;
        pad = wbits - last * b;
        pay = words * wbytes;
      end
      if (pay > PAYLOAD_LIMIT) begin
        pay = (PAYLOAD_LIMIT / wbytes) * wbytes;
        pad = 0;
        r.status = ST_OVF;
      end
    end else begin
      avail = longint'(it.payload_bytes) * 8;
      if (it.pad_bits > avail) begin
        r.status = ST_UNF;
      end else if (dense) begin
        cnt = ((avail - it.pad_bits) / b) / mult;
      end else begin
        spw = wbits / b;
        total = spw * (longint'(it.payload_bytes) / wbytes);
        padsmp = it.pad_bits / b;
        if (padsmp > total) r.status = ST_UNF;
        else cnt = (total - padsmp) / mult;
      end
    end
    r.scount = cnt[CNT_W-1:0];
    r.pay    = pay[PAY_W-1:0];
    r.pad    = pad[PAD_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // scoreboard: predict on input beats, compare on output beats
  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.cmd           = s_axis_tuser[0];
        seen.count_scalar  = s_axis_tuser[1];
        seen.sample_count  = s_axis_tdata[20:0];
        seen.payload_bytes = s_axis_tdata[38:21];
        seen.pad_bits      = s_axis_tdata[44:39];
        pending_sizes.push_back(pin_on ? pin_res : calc_payload_size(seen));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_sizes.size() == 0) begin
          flag_mismatch("result beat with nothing pending", m_axis_tdata, 0);
        end else begin
          want = pending_sizes.pop_front();
          if (m_axis_tdata[20:0] !== want.scount)
            flag_mismatch("sample_count_out", m_axis_tdata[20:0], want.scount);
          if (m_axis_tdata[38:21] !== want.pay)
            flag_mismatch("payload_bytes_out", m_axis_tdata[38:21], want.pay);
          if (m_axis_tdata[44:39] !== want.pad)
            flag_mismatch("pad_bits_out", m_axis_tdata[44:39], want.pad);
          if (m_axis_tuser !== want.status)
            flag_mismatch("status", m_axis_tuser, want.status);
        end
      end
    end
  end

  // receiver: random backpressure, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void add_row(input logic [BPS_W-1:0] bps, input logic cplx,
                                  input logic peff, input logic cmd, input logic scalar,
                                  input int n, input int pb, input int pad,
                                  input logic typed, input int ws, input int wp,
                                  input int wd, input status_t st);
    dir_row_t row;
    row.bps                = bps;
    row.cplx               = cplx;
    row.peff               = peff;
    row.beat.cmd           = cmd;
    row.beat.count_scalar  = scalar;
    row.beat.sample_count  = n[CNT_W-1:0];
    row.beat.payload_bytes = pb[PAY_W-1:0];
    row.beat.pad_bits      = pad[PAD_W-1:0];
    row.typed              = typed;
    row.want.scount        = ws[CNT_W-1:0];
    row.want.pay           = wp[PAY_W-1:0];
    row.want.pad           = wd[PAD_W-1:0];
    row.want.status        = st;
    dir_rows.push_back(row);
  endfunction

  // all calls start and end at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [BPS_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BPS:  cur_bps  = val;
      CFG_CPLX: cur_cplx = val[0];
      CFG_PEFF: cur_peff = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_sizes.size() != 0) @(negedge clk);
  endtask

  task automatic send_beat(input item_t it, input logic typed, input result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    pin_on        = typed;
    pin_res       = want;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, it.pad_bits, it.payload_bytes, it.sample_count};
    s_axis_tuser  = {it.count_scalar, it.cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    pin_on = 1'b0;
  endtask

  // main sequence
  initial begin
    item_t           it;
    result_t         none;
    logic [BPS_W-1:0] nb;
    longint unsigned beff, mult, ovf_n, n;
    int              r;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_BPS;
    cfg_data       = '0;
    cur_bps        = BPS_RESET;
    cur_cplx       = 1'b0;
    cur_peff       = 1'b0;
    src_idle_pct   = 25;
    sink_idle_pct  = 74;
    hold_req       = 1'b0;
    pin_on         = 1'b0;
    pin_res        = '0;
    none           = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset packing: 16 bits, real, link efficient
    add_row(7'd16, 0, 0, CMD_TO_PAYLOAD, 0, 0, 0, 0, 1, 0, 0, 0, ST_OK);
    add_row(7'd16, 0, 0, CMD_TO_PAYLOAD, 0, 1, 0, 0, 1, 0, 4, 16, ST_OK);
    add_row(7'd16, 0, 0, CMD_TO_PAYLOAD, 0, 131070, 0, 0, 1, 0, 262140, 0, ST_OK);
    add_row(7'd16, 0, 0, CMD_TO_PAYLOAD, 0, 131071, 0, 0, 1, 0, 262140, 0, ST_OVF);
    add_row(7'd16, 0, 0, CMD_TO_PAYLOAD, 1, 'h1FFFFF, 'h3FFFF, 63, 1, 0, 262140, 0, ST_OVF);
    add_row(7'd16, 0, 0, CMD_TO_SAMPLES, 0, 0, 0, 0, 1, 0, 0, 0, ST_OK);
    add_row(7'd16, 0, 0, CMD_TO_SAMPLES, 1, 'h1FFFFF, 0, 63, 1, 0, 0, 0, ST_UNF);
    add_row(7'd16, 0, 0, CMD_TO_SAMPLES, 0, 0, 'h3FFFF, 63, 0, 0, 0, 0, ST_OK);
    // complex pairs, counted as pairs and as scalars
    add_row(7'd16, 1, 0, CMD_TO_PAYLOAD, 0, 3, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd16, 1, 0, CMD_TO_PAYLOAD, 1, 3, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd16, 1, 0, CMD_TO_SAMPLES, 0, 0, 100, 5, 0, 0, 0, 0, ST_OK);
    // packing size zero behaves as one bit
    add_row(7'd0, 0, 1, CMD_TO_PAYLOAD, 0, 33, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd0, 0, 1, CMD_TO_SAMPLES, 0, 0, 9, 7, 0, 0, 0, 0, ST_OK);
    // packing size above 64 behaves as 64
    add_row(7'd100, 0, 1, CMD_TO_PAYLOAD, 0, 5, 0, 0, 0, 0, 0, 0, ST_OK);
    // processing efficient, one sample per 32-bit word
    add_row(7'd24, 0, 1, CMD_TO_PAYLOAD, 0, 5, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd24, 0, 1, CMD_TO_SAMPLES, 0, 0, 8, 24, 0, 0, 0, 0, ST_OK);
    // processing efficient, three samples per word; pad samples beyond whole words
    add_row(7'd10, 0, 1, CMD_TO_PAYLOAD, 0, 7, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd10, 0, 1, CMD_TO_SAMPLES, 0, 0, 4, 31, 0, 0, 0, 0, ST_OK);
    add_row(7'd10, 0, 1, CMD_TO_SAMPLES, 0, 0, 3, 20, 1, 0, 0, 0, ST_UNF);
    // 64-bit word, overflow saturates to a multiple of 8
    add_row(7'd33, 1, 1, CMD_TO_PAYLOAD, 0, 'h1FFFFF, 0, 0, 1, 0, 262136, 0, ST_OVF);
    add_row(7'd33, 1, 1, CMD_TO_SAMPLES, 0, 0, 'h3FFFF, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd63, 1, 1, CMD_TO_PAYLOAD, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK);
    // size extremes
    add_row(7'd64, 0, 0, CMD_TO_PAYLOAD, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(7'd1, 0, 0, CMD_TO_SAMPLES, 0, 0, 'h3FFFF, 0, 0, 0, 0, 0, ST_OK);

    // walk the table, reprogramming only when the packing changes
    foreach (dir_rows[i]) begin
      if (dir_rows[i].bps != cur_bps || dir_rows[i].cplx != cur_cplx ||
          dir_rows[i].peff != cur_peff) begin
        wait_drained();
        if (dir_rows[i].bps != cur_bps) write_reg(CFG_BPS, dir_rows[i].bps);
        if (dir_rows[i].cplx != cur_cplx) write_reg(CFG_CPLX, {6'd0, dir_rows[i].cplx});
        if (dir_rows[i].peff != cur_peff) write_reg(CFG_PEFF, {6'd0, dir_rows[i].peff});
      end
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases: receiver-idle heavy, sender-idle heavy, then full rate with one long hold
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 74 : 0;
      sink_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 25 : 0;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k % RECONFIG_EVERY == 0) begin
          wait_drained();
          r = $urandom_range(9);
          case (r)
            0: begin
              case ($urandom_range(4))
                0: nb = 7'd0;
                1: nb = 7'd1;
                2: nb = 7'd64;
                3: nb = 7'd65;
                default: nb = 7'd127;
              endcase
            end
            1: nb = BPS_W'($urandom_range(0, 127));
            default: nb = BPS_W'($urandom_range(1, 64));
          endcase
          write_reg(CFG_BPS, nb);
          write_reg(CFG_CPLX, {6'd0, 1'($urandom_range(1))});
          write_reg(CFG_PEFF, {6'd0, 1'($urandom_range(1))});
          if (ph == 2 && k == 0) hold_req = 1'b1;
        end
        it.cmd          = 1'($urandom_range(1));
        it.count_scalar = 1'($urandom_range(1));
        it.pad_bits     = PAD_W'($urandom_range(0, 63));
        // sample count: mostly small, some anywhere, some around the overflow point
        beff = (cur_bps == 0) ? 1 : (cur_bps > 64) ? 64 : cur_bps;
        mult = (cur_cplx && !it.count_scalar) ? 2 : 1;
        ovf_n = (longint'(PAYLOAD_LIMIT) * 8) / (beff * mult);
        r = $urandom_range(9);
        if (r < 4) n = $urandom_range(0, 63);
        else if (r < 6) n = $urandom_range(0, 20000);
        else if (r < 8) n = $urandom;
        else n = (ovf_n > 64 ? ovf_n - 64 : 0) + $urandom_range(0, 128);
        it.sample_count = n[CNT_W-1:0];
        r = $urandom_range(9);
        if (r < 4) it.payload_bytes = PAY_W'($urandom_range(0, 40));
        else if (r < 8) it.payload_bytes = PAY_W'($urandom);
        else it.payload_bytes = PAY_W'($urandom_range(262080, 262143));
        send_beat(it, 1'b0, none);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
